@@ hw/rtl/mbt_pkg.sv @@
// Shared constants, types and helper functions of the perceptron trainer.
package mbt_pkg;

  localparam int unsigned NUM_INPUTS      = 2;
  localparam int unsigned NUM_HIDDEN      = 2;
  localparam int unsigned WEIGHT_BITS     = 24;
  localparam int unsigned SIGMOID_ENTRIES = 1024;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned ACT_W = 13;
  localparam int unsigned TGT_W = 13;
  localparam int unsigned ERR_W = 14;
  localparam int unsigned SQ_W  = 25;
  localparam int unsigned LR_W  = 16;
  localparam logic [LR_W-1:0] LR_RESET = 16'd8192;
  localparam logic [ACT_W-1:0] ONE_Q12  = 13'd4096;
  localparam logic [ACT_W-1:0] HALF_Q12 = 13'd2048;

  localparam int unsigned S_TDATA_W = ((2 * IN_W + TGT_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((ACT_W + 1 + ERR_W + SQ_W + 7) / 8) * 8;

  localparam int unsigned SIG_AW      = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned SIG_HALF    = SIGMOID_ENTRIES / 2;
  localparam int unsigned SIG_SPACING = 65536 / SIGMOID_ENTRIES;
  localparam int unsigned SPC_W       = $clog2(SIG_SPACING);
  localparam logic [31:0] EXP_STEP    = 32'd4293918848;

  localparam int unsigned OFS_WHO = NUM_INPUTS * NUM_HIDDEN;
  localparam int unsigned OFS_BH  = OFS_WHO + NUM_HIDDEN;
  localparam int unsigned OFS_BO  = OFS_BH + NUM_HIDDEN;
  localparam int unsigned NUM_W   = OFS_BO + 1;
  localparam int unsigned W_AW    = $clog2(NUM_W);
  localparam int unsigned IN_IW   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned HID_IW  = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

  localparam int unsigned OPA_W  = WEIGHT_BITS + 4;
  localparam int unsigned OPB_W  = 17;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned SUM_W  = WEIGHT_BITS + 5 + $clog2(NUM_INPUTS + NUM_HIDDEN + 1);

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE,
    ST_HB_RD, ST_HB, ST_HW_RD, ST_HW_MUL, ST_HW_ACC, ST_HS_RD, ST_HS,
    ST_OB_RD, ST_OB, ST_OW_RD, ST_OW_MUL, ST_OW_ACC, ST_YS_RD, ST_YS,
    ST_SQ_MUL, ST_RES,
    ST_DY_MUL, ST_OD_MUL, ST_G_MUL, ST_G,
    ST_HD_RD, ST_HD_MUL, ST_HD_DH, ST_HD_MUL2, ST_HD_LR, ST_HD_SET,
    ST_UO_RD, ST_UO_MUL, ST_UO_WR, ST_UB_RD, ST_UB_WR,
    ST_UHB_RD, ST_UHB_WR, ST_UI_RD, ST_UI_MUL, ST_UI_WR
  } trn_state_e;

  typedef enum logic [2:0] {
    BLD_POW_MUL, BLD_POW_SH, BLD_START, BLD_DIV, BLD_WR, BLD_EXP_MUL, BLD_EXP_SH, BLD_DONE
  } bld_state_e;

  // Write port of the sigmoid table while it is being built.
  typedef struct packed {
    logic              we;
    logic [SIG_AW-1:0] addr;
    logic [ACT_W-1:0]  data;
    logic              done;
  } sig_wr_t;

  // Power-on value of weight memory entry idx.
  function automatic logic [WEIGHT_BITS-1:0] w_reset(input int unsigned idx);
    logic [WEIGHT_BITS-1:0] v;
    v = WEIGHT_BITS'(2458);
    if (idx < OFS_WHO) begin
      case (idx % 4)
        0: v = WEIGHT_BITS'(614);
        1: v = WEIGHT_BITS'(1024);
        2: v = WEIGHT_BITS'(819);
        default: v = WEIGHT_BITS'(1229);
      endcase
    end else if (idx < OFS_BH) begin
      v = ((idx - OFS_WHO) % 2 == 0) ? WEIGHT_BITS'(1638) : WEIGHT_BITS'(2048);
    end else if (idx < OFS_BO) begin
      v = WEIGHT_BITS'(1434);
    end
    return v;
  endfunction

  // Saturate an updated weight to the signed weight range.
  function automatic logic signed [WEIGHT_BITS-1:0] sat_w(input logic signed [OPA_W:0] v);
    logic signed [OPA_W:0] hi;
    logic signed [OPA_W:0] lo;
    hi = {{(OPA_W - WEIGHT_BITS + 2){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
    lo = {{(OPA_W - WEIGHT_BITS + 2){1'b1}}, {(WEIGHT_BITS - 1){1'b0}}};
    if (v > hi) return {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
    if (v < lo) return {1'b1, {(WEIGHT_BITS - 1){1'b0}}};
    return v[WEIGHT_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/mbt_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
module mbt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/mbt_sig_builder.sv @@
// Sequencer that computes the sigmoid table entries after reset.
module mbt_sig_builder (
  input  logic             clk_i,
  input  logic             rst_ni,
  output mbt_pkg::sig_wr_t wr_o
);

  localparam int unsigned SAW = mbt_pkg::SIG_AW;
  localparam int unsigned SPW = mbt_pkg::SPC_W;

  mbt_pkg::bld_state_e state_q, state_d;

  logic [32:0]    b_q, e_q;
  logic [65:0]    prod_q;
  logic [SPW-1:0] k_q;
  logic [SAW-1:0] m_q;
  logic           neg_q;
  logic [45:0]    rem_q, dv_q;
  logic [12:0]    quo_q;
  logic [3:0]     bit_q;
  logic [33:0]    den;
  logic           ge;
  logic           m_is_half;

  assign den       = 34'(e_q) + (34'd1 << 32);
  assign ge        = (rem_q >= dv_q);
  assign m_is_half = (m_q == SAW'(mbt_pkg::SIG_HALF));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbt_pkg::BLD_POW_MUL: state_d = mbt_pkg::BLD_POW_SH;
      mbt_pkg::BLD_POW_SH: begin
        if (k_q == SPW'(mbt_pkg::SIG_SPACING - 1)) state_d = mbt_pkg::BLD_START;
        else state_d = mbt_pkg::BLD_POW_MUL;
      end
      mbt_pkg::BLD_START: state_d = mbt_pkg::BLD_DIV;
      mbt_pkg::BLD_DIV: begin
        if (bit_q == 4'd12) state_d = mbt_pkg::BLD_WR;
      end
      mbt_pkg::BLD_WR: begin
        if (!neg_q && m_q != '0) state_d = mbt_pkg::BLD_START;
        else if (m_is_half) state_d = mbt_pkg::BLD_DONE;
        else state_d = mbt_pkg::BLD_EXP_MUL;
      end
      mbt_pkg::BLD_EXP_MUL: state_d = mbt_pkg::BLD_EXP_SH;
      mbt_pkg::BLD_EXP_SH:  state_d = mbt_pkg::BLD_START;
      mbt_pkg::BLD_DONE:    state_d = mbt_pkg::BLD_DONE;
      default:              state_d = mbt_pkg::BLD_DONE;
    endcase
  end

  always_comb begin
    wr_o.we   = (state_q == mbt_pkg::BLD_WR);
    wr_o.addr = neg_q ? SAW'(SAW'(mbt_pkg::SIG_HALF) - m_q)
                      : SAW'(SAW'(mbt_pkg::SIG_HALF) + m_q);
    wr_o.data = quo_q;
    wr_o.done = (state_q == mbt_pkg::BLD_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbt_pkg::BLD_POW_MUL;
      b_q     <= 33'd1 << 32;
      e_q     <= 33'd1 << 32;
      k_q     <= '0;
      m_q     <= '0;
      neg_q   <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mbt_pkg::BLD_POW_SH: begin
          b_q <= prod_q[64:32];
          k_q <= SPW'(k_q + 1'b1);
        end
        mbt_pkg::BLD_START: bit_q <= '0;
        mbt_pkg::BLD_DIV:   bit_q <= 4'(bit_q + 1'b1);
        mbt_pkg::BLD_WR: begin
          if (!neg_q && m_q != '0) neg_q <= 1'b1;
        end
        mbt_pkg::BLD_EXP_SH: begin
          e_q   <= prod_q[64:32];
          m_q   <= SAW'(m_q + 1'b1);
          neg_q <= (SAW'(m_q + 1'b1) == SAW'(mbt_pkg::SIG_HALF));
        end
        default: ;
      endcase
    end
  end

  // Multiplier and restoring divider; quotients never exceed 4096, so 13 steps suffice.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mbt_pkg::BLD_POW_MUL: prod_q <= 66'(b_q) * 66'({1'b0, mbt_pkg::EXP_STEP});
      mbt_pkg::BLD_EXP_MUL: prod_q <= 66'(e_q) * 66'(b_q);
      mbt_pkg::BLD_START: begin
        rem_q <= neg_q ? (46'({e_q, 12'b0}) + 46'(den >> 1))
                       : ((46'd1 << 44) + 46'(den >> 1));
        dv_q  <= {den, 12'b0};
        quo_q <= '0;
      end
      mbt_pkg::BLD_DIV: begin
        if (ge) rem_q <= rem_q - dv_q;
        quo_q <= {quo_q[11:0], ge};
        dv_q  <= dv_q >> 1;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/mlp_backprop_trainer.sv @@
// Top level of the two-layer sigmoid perceptron with on-line backpropagation training.
// After reset the block builds its sigmoid table
// (exponentials by repeated Q.32 multiplication, each entry by a 13-step restoring
// divider) and loads the power-on weights, and it takes no word in that time; the
// learning-rate register can be written throughout. Each input word carries two
// signed Q3.12 inputs, a Q1.12 target and a train flag in tuser. Weights and biases
// live in a small synchronous RAM; one sequencer walks the forward pass, and for train
// words the backward pass and the read-modify-write of every weight, through a single
// shared registered multiplier. Every weight read passes the registered RAM port and
// every product the multiplier register. After an infer word the next word is taken
// once its result is loaded, after a train word only once the last weight is written
// back, which is also what keeps training strictly in order. The result word sits in
// an output register, so a stalled consumer only holds the sequencer at the moment
// a new result must be loaded.
module mlp_backprop_trainer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbt_pkg::LR_W-1:0]        cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // in_first [15:0], in_second [31:16], target [44:32], zero fill above.
  input  logic [mbt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind [0]: 0 infer only, 1 infer then train.
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // prediction [12:0], class_bit [13], error [27:14], squared_error [52:28], zero fill.
  output logic [mbt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned WB   = mbt_pkg::WEIGHT_BITS;
  localparam int unsigned WAW  = mbt_pkg::W_AW;
  localparam int unsigned SAW  = mbt_pkg::SIG_AW;
  localparam int unsigned OPA  = mbt_pkg::OPA_W;
  localparam int unsigned OPB  = mbt_pkg::OPB_W;
  localparam int unsigned SUMW = mbt_pkg::SUM_W;
  localparam int unsigned IIW  = mbt_pkg::IN_IW;
  localparam int unsigned HIW  = mbt_pkg::HID_IW;
  localparam int unsigned AW   = mbt_pkg::ACT_W;
  localparam int unsigned EW   = mbt_pkg::ERR_W;
  localparam logic signed [SUMW-1:0] SIG_HI = SUMW'(32767);
  localparam logic signed [SUMW-1:0] SIG_LO = -SUMW'(32768);

  mbt_pkg::trn_state_e state_q, state_d;

  logic [mbt_pkg::LR_W-1:0] lr_q;
  logic [IIW-1:0]           i_q;
  logic [HIW-1:0]           j_q;
  logic [WAW-1:0]           init_cnt_q;
  logic                     init_done_q;
  logic                     out_valid_q;
  logic [mbt_pkg::M_TDATA_W-1:0] out_data_q;

  logic signed [mbt_pkg::IN_W-1:0] x_q [mbt_pkg::NUM_INPUTS];
  logic [AW-1:0]                   h_q [mbt_pkg::NUM_HIDDEN];
  logic signed [OPA-1:0]           gj_q [mbt_pkg::NUM_HIDDEN];
  logic [mbt_pkg::TGT_W-1:0]       tgt_q;
  logic                            train_q;
  logic signed [SUMW-1:0]          sum_q;
  logic [AW-1:0]                   y_q;
  logic signed [EW-1:0]            err_q;
  logic signed [OPB-1:0]           od_q;
  logic signed [OPA-1:0]           g_q, t_q;
  logic signed [WB-1:0]            wq_q;
  logic signed [mbt_pkg::PROD_W-1:0] prod_q;

  logic                   in_acc;
  logic                   res_load;
  logic                   i_last, j_last;
  logic                   mul_en;
  logic signed [OPA-1:0]  mul_a;
  logic signed [OPB-1:0]  mul_b;
  logic signed [OPA-1:0]  prodsh;
  logic signed [OPB-1:0]  prodsh_b;
  logic                   w_we;
  logic [WAW-1:0]         w_waddr, w_raddr, ih_addr;
  logic [WB-1:0]          w_wdata, w_rdata;
  logic signed [WB-1:0]   w_rd;
  logic signed [WB-1:0]   upd_base;
  logic signed [OPA-1:0]  upd_delta;
  logic [SAW-1:0]         sig_raddr;
  logic [AW-1:0]          sig_rdata;
  logic signed [SUMW-1:0] sum_cl;
  logic [15:0]            sig_off;
  logic [mbt_pkg::TGT_W-1:0] tgt_in;
  logic signed [EW-1:0]   err_new;
  mbt_pkg::sig_wr_t       sig_wr;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign i_last   = (i_q == IIW'(mbt_pkg::NUM_INPUTS - 1));
  assign j_last   = (j_q == HIW'(mbt_pkg::NUM_HIDDEN - 1));
  assign prodsh   = prod_q[OPA+11:12];
  assign prodsh_b = prodsh[OPB-1:0];
  assign w_rd     = w_rdata;
  assign ih_addr  = WAW'(WAW'(i_q) * WAW'(mbt_pkg::NUM_HIDDEN) + WAW'(j_q));
  assign tgt_in   = (s_axis_tdata[44:32] > mbt_pkg::ONE_Q12) ? mbt_pkg::ONE_Q12
                                                             : s_axis_tdata[44:32];
  assign err_new  = $signed({1'b0, tgt_q}) - $signed({1'b0, sig_rdata});

  // The pre-activation is clamped to [-8, 8) and offset to an unsigned table index.
  assign sum_cl    = (sum_q > SIG_HI) ? SIG_HI : ((sum_q < SIG_LO) ? SIG_LO : sum_q);
  assign sig_off   = {~sum_cl[15], sum_cl[14:0]};
  assign sig_raddr = sig_off[15 -: SAW];

  mbt_sig_builder u_builder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (sig_wr)
  );

  mbt_ram #(
    .DEPTH (mbt_pkg::SIGMOID_ENTRIES),
    .WIDTH (AW)
  ) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (sig_wr.we),
    .waddr_i (sig_wr.addr),
    .wdata_i (sig_wr.data),
    .raddr_i (sig_raddr),
    .rdata_o (sig_rdata)
  );

  mbt_ram #(
    .DEPTH (mbt_pkg::NUM_W),
    .WIDTH (WB)
  ) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbt_pkg::ST_INIT: begin
        if (init_done_q && sig_wr.done) state_d = mbt_pkg::ST_IDLE;
      end
      mbt_pkg::ST_IDLE:   if (in_acc) state_d = mbt_pkg::ST_HB_RD;
      mbt_pkg::ST_HB_RD:  state_d = mbt_pkg::ST_HB;
      mbt_pkg::ST_HB:     state_d = mbt_pkg::ST_HW_RD;
      mbt_pkg::ST_HW_RD:  state_d = mbt_pkg::ST_HW_MUL;
      mbt_pkg::ST_HW_MUL: state_d = mbt_pkg::ST_HW_ACC;
      mbt_pkg::ST_HW_ACC: state_d = i_last ? mbt_pkg::ST_HS_RD : mbt_pkg::ST_HW_RD;
      mbt_pkg::ST_HS_RD:  state_d = mbt_pkg::ST_HS;
      mbt_pkg::ST_HS:     state_d = j_last ? mbt_pkg::ST_OB_RD : mbt_pkg::ST_HB_RD;
      mbt_pkg::ST_OB_RD:  state_d = mbt_pkg::ST_OB;
      mbt_pkg::ST_OB:     state_d = mbt_pkg::ST_OW_RD;
      mbt_pkg::ST_OW_RD:  state_d = mbt_pkg::ST_OW_MUL;
      mbt_pkg::ST_OW_MUL: state_d = mbt_pkg::ST_OW_ACC;
      mbt_pkg::ST_OW_ACC: state_d = j_last ? mbt_pkg::ST_YS_RD : mbt_pkg::ST_OW_RD;
      mbt_pkg::ST_YS_RD:  state_d = mbt_pkg::ST_YS;
      mbt_pkg::ST_YS:     state_d = mbt_pkg::ST_SQ_MUL;
      mbt_pkg::ST_SQ_MUL: state_d = mbt_pkg::ST_RES;
      mbt_pkg::ST_RES: begin
        if (res_load) state_d = train_q ? mbt_pkg::ST_DY_MUL : mbt_pkg::ST_IDLE;
      end
      mbt_pkg::ST_DY_MUL:  state_d = mbt_pkg::ST_OD_MUL;
      mbt_pkg::ST_OD_MUL:  state_d = mbt_pkg::ST_G_MUL;
      mbt_pkg::ST_G_MUL:   state_d = mbt_pkg::ST_G;
      mbt_pkg::ST_G:       state_d = mbt_pkg::ST_HD_RD;
      mbt_pkg::ST_HD_RD:   state_d = mbt_pkg::ST_HD_MUL;
      mbt_pkg::ST_HD_MUL:  state_d = mbt_pkg::ST_HD_DH;
      mbt_pkg::ST_HD_DH:   state_d = mbt_pkg::ST_HD_MUL2;
      mbt_pkg::ST_HD_MUL2: state_d = mbt_pkg::ST_HD_LR;
      mbt_pkg::ST_HD_LR:   state_d = mbt_pkg::ST_HD_SET;
      mbt_pkg::ST_HD_SET:  state_d = j_last ? mbt_pkg::ST_UO_RD : mbt_pkg::ST_HD_RD;
      mbt_pkg::ST_UO_RD:   state_d = mbt_pkg::ST_UO_MUL;
      mbt_pkg::ST_UO_MUL:  state_d = mbt_pkg::ST_UO_WR;
      mbt_pkg::ST_UO_WR:   state_d = j_last ? mbt_pkg::ST_UB_RD : mbt_pkg::ST_UO_RD;
      mbt_pkg::ST_UB_RD:   state_d = mbt_pkg::ST_UB_WR;
      mbt_pkg::ST_UB_WR:   state_d = mbt_pkg::ST_UHB_RD;
      mbt_pkg::ST_UHB_RD:  state_d = mbt_pkg::ST_UHB_WR;
      mbt_pkg::ST_UHB_WR:  state_d = mbt_pkg::ST_UI_RD;
      mbt_pkg::ST_UI_RD:   state_d = mbt_pkg::ST_UI_MUL;
      mbt_pkg::ST_UI_MUL:  state_d = mbt_pkg::ST_UI_WR;
      mbt_pkg::ST_UI_WR: begin
        if (!i_last) state_d = mbt_pkg::ST_UI_RD;
        else if (!j_last) state_d = mbt_pkg::ST_UHB_RD;
        else state_d = mbt_pkg::ST_IDLE;
      end
      default: state_d = mbt_pkg::ST_IDLE;
    endcase
  end

  // Memory addresses, multiplier operands and write-back values for each step.
  always_comb begin
    s_axis_tready = (state_q == mbt_pkg::ST_IDLE);
    res_load      = (state_q == mbt_pkg::ST_RES) && (!out_valid_q || m_axis_tready);
    w_raddr   = ih_addr;
    w_we      = 1'b0;
    w_waddr   = ih_addr;
    upd_base  = wq_q;
    upd_delta = prodsh;
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      mbt_pkg::ST_INIT: begin
        w_we    = !init_done_q;
        w_waddr = init_cnt_q;
        mul_en  = 1'b0;
      end
      mbt_pkg::ST_HB_RD, mbt_pkg::ST_UHB_RD: w_raddr = WAW'(WAW'(mbt_pkg::OFS_BH) + WAW'(j_q));
      mbt_pkg::ST_OB_RD, mbt_pkg::ST_UB_RD:  w_raddr = WAW'(mbt_pkg::OFS_BO);
      mbt_pkg::ST_OW_RD, mbt_pkg::ST_HD_RD, mbt_pkg::ST_UO_RD:
        w_raddr = WAW'(WAW'(mbt_pkg::OFS_WHO) + WAW'(j_q));
      mbt_pkg::ST_HW_MUL: begin
        mul_a = OPA'(w_rd);
        mul_b = OPB'(x_q[i_q]);
      end
      mbt_pkg::ST_OW_MUL: begin
        mul_a = OPA'(w_rd);
        mul_b = OPB'(h_q[j_q]);
      end
      mbt_pkg::ST_SQ_MUL: begin
        mul_a = OPA'(err_q);
        mul_b = OPB'(err_q);
      end
      mbt_pkg::ST_DY_MUL: begin
        mul_a = OPA'(y_q);
        mul_b = OPB'(mbt_pkg::ONE_Q12 - y_q);
      end
      mbt_pkg::ST_OD_MUL: begin
        mul_a = OPA'(err_q);
        mul_b = prodsh_b;
      end
      mbt_pkg::ST_G_MUL, mbt_pkg::ST_HD_LR: begin
        mul_a = prodsh;
        mul_b = OPB'(lr_q);
      end
      mbt_pkg::ST_HD_MUL: begin
        mul_a = OPA'(w_rd);
        mul_b = od_q;
      end
      mbt_pkg::ST_HD_DH: begin
        mul_a = OPA'(h_q[j_q]);
        mul_b = OPB'(mbt_pkg::ONE_Q12 - h_q[j_q]);
      end
      mbt_pkg::ST_HD_MUL2: begin
        mul_a = t_q;
        mul_b = prodsh_b;
      end
      mbt_pkg::ST_UO_MUL: begin
        mul_a = g_q;
        mul_b = OPB'(h_q[j_q]);
      end
      mbt_pkg::ST_UI_MUL: begin
        mul_a = gj_q[j_q];
        mul_b = OPB'(x_q[i_q]);
      end
      mbt_pkg::ST_UO_WR: begin
        w_we    = 1'b1;
        w_waddr = WAW'(WAW'(mbt_pkg::OFS_WHO) + WAW'(j_q));
      end
      mbt_pkg::ST_UB_WR: begin
        w_we      = 1'b1;
        w_waddr   = WAW'(mbt_pkg::OFS_BO);
        upd_base  = w_rd;
        upd_delta = g_q;
      end
      mbt_pkg::ST_UHB_WR: begin
        w_we      = 1'b1;
        w_waddr   = WAW'(WAW'(mbt_pkg::OFS_BH) + WAW'(j_q));
        upd_base  = w_rd;
        upd_delta = gj_q[j_q];
      end
      mbt_pkg::ST_UI_WR: w_we = 1'b1;
      mbt_pkg::ST_RES: mul_en = 1'b0;
      default: ;
    endcase
    if (state_q == mbt_pkg::ST_INIT) begin
      w_wdata = mbt_pkg::w_reset(32'(init_cnt_q));
    end else begin
      w_wdata = mbt_pkg::sat_w((OPA + 1)'(upd_base) + (OPA + 1)'(upd_delta));
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbt_pkg::ST_INIT;
      lr_q        <= mbt_pkg::LR_RESET;
      i_q         <= '0;
      j_q         <= '0;
      init_cnt_q  <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lr_q <= cfg_wdata_i;
      if (state_q == mbt_pkg::ST_INIT && !init_done_q) begin
        init_cnt_q <= WAW'(init_cnt_q + 1'b1);
        if (init_cnt_q == WAW'(mbt_pkg::NUM_W - 1)) init_done_q <= 1'b1;
      end
      if (res_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        mbt_pkg::ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
        end
        mbt_pkg::ST_HB, mbt_pkg::ST_UHB_WR: i_q <= '0;
        mbt_pkg::ST_HW_ACC: if (!i_last) i_q <= IIW'(i_q + 1'b1);
        mbt_pkg::ST_HS, mbt_pkg::ST_OW_ACC, mbt_pkg::ST_HD_SET, mbt_pkg::ST_UO_WR:
          j_q <= j_last ? '0 : HIW'(j_q + 1'b1);
        mbt_pkg::ST_UI_WR: begin
          if (!i_last) i_q <= IIW'(i_q + 1'b1);
          else if (!j_last) j_q <= HIW'(j_q + 1'b1);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    if (in_acc) begin
      for (int n = 0; n < mbt_pkg::NUM_INPUTS; n++) begin
        if (n == 0) x_q[n] <= s_axis_tdata[15:0];
        else if (n == 1) x_q[n] <= s_axis_tdata[31:16];
        else x_q[n] <= '0;
      end
      tgt_q   <= tgt_in;
      train_q <= s_axis_tuser[0];
    end
    if (res_load) begin
      out_data_q <= mbt_pkg::M_TDATA_W'({prod_q[mbt_pkg::SQ_W-1:0], err_q,
                                         (y_q > mbt_pkg::HALF_Q12), y_q});
    end
    case (state_q)
      mbt_pkg::ST_HB, mbt_pkg::ST_OB: sum_q <= SUMW'(w_rd);
      mbt_pkg::ST_HW_ACC, mbt_pkg::ST_OW_ACC: sum_q <= sum_q + SUMW'(prodsh);
      mbt_pkg::ST_HS: h_q[j_q] <= sig_rdata;
      mbt_pkg::ST_YS: begin
        y_q   <= sig_rdata;
        err_q <= err_new;
      end
      mbt_pkg::ST_G_MUL:  od_q <= prodsh_b;
      mbt_pkg::ST_G:      g_q <= prodsh;
      mbt_pkg::ST_HD_DH:  t_q <= prodsh;
      mbt_pkg::ST_HD_SET: gj_q[j_q] <= prodsh;
      mbt_pkg::ST_UO_MUL, mbt_pkg::ST_UI_MUL: wq_q <= w_rd;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The weight RAM is never written in the cycle that a new word enters.
  assert property (@(posedge clk_i) disable iff (!rst_ni) w_we |-> !in_acc)
    else $error("weight write overlaps word acceptance");

  // The sigmoid table is only written before the first word can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_wr.we |-> state_q == mbt_pkg::ST_INIT)
    else $error("sigmoid table written outside of initialization");

  // A result is only loaded when the output register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrites a pending word");

  // An accepted word always starts the forward pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mbt_pkg::ST_HB_RD)
    else $error("accepted word did not start the forward pass");

  // A reported prediction never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:0] <= mbt_pkg::ONE_Q12)
    else $error("prediction out of range");

endmodule

@@ bench/mlp_backprop_trainer_test.sv @@
// Self-checking bench for the perceptron trainer: random and directed words scored live.
`timescale 1ns / 100ps

module mlp_backprop_trainer_test;
  import mbt_pkg::*;

  // One expected result word, unpacked into its fields.
  typedef struct {
    logic [ACT_W-1:0] prediction;
    logic             class_bit;
    logic [ERR_W-1:0] error;
    logic [SQ_W-1:0]  squared_error;
  } net_result_t;

  // Scoreboard: a fixed-point twin of the network plus the queue of pending results.
  class net_scoreboard;
    longint           w_ih[NUM_INPUTS*NUM_HIDDEN];
    longint           w_ho[NUM_HIDDEN];
    longint           b_hid[NUM_HIDDEN];
    longint           b_out;
    longint           gain;
    logic [ACT_W-1:0] sig_rom[SIGMOID_ENTRIES];
    net_result_t      pending[$];
    int               mismatches;

    function new();
      longint unsigned step, e, den;
      w_ih = '{614, 1024, 819, 1229};
      w_ho = '{1638, 2048};
      b_hid = '{1434, 1434};
      b_out = 2458;
      gain = longint'(LR_RESET);
      mismatches = 0;
      // Exponentials are built by repeated truncated Q.32 products, as in hardware.
      step = 64'd1 << 32;
      for (int k = 0; k < SIG_SPACING; k++) step = (step * 64'd4293918848) >> 32;
      e = 64'd1 << 32;
      for (int m = 0; m <= SIG_HALF; m++) begin
        den = (64'd1 << 32) + e;
        if (SIG_HALF + m < SIGMOID_ENTRIES)
          sig_rom[SIG_HALF+m] = ACT_W'(((64'd1 << 44) + den / 2) / den);
        if (m > 0) sig_rom[SIG_HALF-m] = ACT_W'(((e << 12) + den / 2) / den);
        e = (e * step) >> 32;
      end
    endfunction

    // Truncating Q.12 product: arithmetic shift floors toward minus infinity.
    function longint qmul(longint a, longint b);
      return (a * b) >>> 12;
    endfunction

    function longint clip_w(longint v);
      longint lim;
      lim = longint'(1) << (WEIGHT_BITS - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint sigmoid(longint s);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return longint'(sig_rom[(s + 32768) / SIG_SPACING]);
    endfunction

    function longint slope(longint a);
      return qmul(a, 4096 - a);
    endfunction

    // Called for every accepted input word; runs forward and, if asked, training.
    function void note_word(bit train, logic [15:0] a0, logic [15:0] a1, logic [12:0] tg);
      longint x[NUM_INPUTS], h[NUM_HIDDEN], hd[NUM_HIDDEN];
      longint s, y, t, err, od, g, gj;
      net_result_t r;
      x[0] = longint'(signed'(a0));
      x[1] = longint'(signed'(a1));
      t = (tg > 4096) ? 4096 : longint'(tg);
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        s = b_hid[j];
        for (int i = 0; i < NUM_INPUTS; i++) s += qmul(x[i], w_ih[i*NUM_HIDDEN+j]);
        h[j] = sigmoid(s);
      end
      s = b_out;
      for (int j = 0; j < NUM_HIDDEN; j++) s += qmul(h[j], w_ho[j]);
      y = sigmoid(s);
      err = t - y;
      r.prediction = ACT_W'(y);
      r.class_bit = (y > 2048);
      r.error = ERR_W'(err);
      r.squared_error = SQ_W'(err * err);
      pending.push_back(r);
      if (train) begin
        // Backward deltas use the weights as they stood before this step.
        od = qmul(err, slope(y));
        for (int j = 0; j < NUM_HIDDEN; j++) hd[j] = qmul(qmul(od, w_ho[j]), slope(h[j]));
        g = qmul(gain, od);
        for (int j = 0; j < NUM_HIDDEN; j++) w_ho[j] = clip_w(w_ho[j] + qmul(g, h[j]));
        b_out = clip_w(b_out + g);
        for (int j = 0; j < NUM_HIDDEN; j++) begin
          gj = qmul(gain, hd[j]);
          for (int i = 0; i < NUM_INPUTS; i++)
            w_ih[i*NUM_HIDDEN+j] = clip_w(w_ih[i*NUM_HIDDEN+j] + qmul(gj, x[i]));
          b_hid[j] = clip_w(b_hid[j] + gj);
        end
      end
    endfunction

    // Called for every accepted result word; compares it against the oldest expectation.
    function void check_word(logic [M_TDATA_W-1:0] d);
      net_result_t r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", d);
        return;
      end
      r = pending.pop_front();
      if (d[12:0] !== r.prediction || d[13] !== r.class_bit || d[27:14] !== r.error ||
          d[52:28] !== r.squared_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: got pred %0d cls %0d err %0d sq %0d, want %0d %0d %0d %0d",
                   d[12:0], d[13], $signed(d[27:14]), d[52:28], r.prediction,
                   r.class_bit, $signed(r.error), r.squared_error);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [LR_W-1:0]        cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  net_scoreboard trainer_sb = new();
  bit calm_sender = 0;   // when set, the sender offers words back to back
  bit calm_receiver = 0; // when set, the receiver never idles
  int hold_request = 0;  // receiver hold-off length, picked up by the receiver process

  always #1 clk_i = ~clk_i;

  mlp_backprop_trainer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Receiver: scores every accepted result word and throttles tready.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) trainer_sb.check_word(m_axis_tdata);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_receiver || ($urandom_range(99) >= 38);
      end
    end
  end

  // Offers one input word, sometimes after a random gap, and waits until it is taken.
  task automatic send_word(bit train, logic [15:0] a0, logic [15:0] a1, logic [12:0] tg);
    if (!calm_sender && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= train;
    s_axis_tdata <= S_TDATA_W'({tg, a1, a0});
    do @(posedge clk_i); while (!s_axis_tready);
    trainer_sb.note_word(train, a0, a1, tg);
  endtask

  // Random word: mostly plausible training samples, some full-range noise.
  task automatic send_random();
    logic [15:0] a0, a1;
    logic [12:0] tg;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // Binary XOR-style samples, the classic training set for this network.
      a0 = $urandom_range(1) ? 16'd4096 : 16'd0;
      a1 = $urandom_range(1) ? 16'd4096 : 16'd0;
      tg = ((a0 != 0) ^ (a1 != 0)) ? 13'd4096 : 13'd0;
    end else if (pick < 80) begin
      a0 = 16'($signed($urandom_range(16384)) - 8192);
      a1 = 16'($signed($urandom_range(16384)) - 8192);
      tg = 13'($urandom_range(4096));
    end else begin
      a0 = 16'($urandom);
      a1 = 16'($urandom);
      tg = 13'($urandom);
    end
    send_word($urandom_range(99) < 70, a0, a1, tg);
  endtask

  // Waits until every expected result is in, then lets the weight write-back finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (trainer_sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_gain(logic [LR_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trainer_sb.gain = longint'(v);
  endtask

  initial begin
    logic [LR_W-1:0] gains[6];
    gains = '{16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd0, 16'd8192};
    gains[4] = LR_W'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset learning rate: field extremes, both kinds,
    // and targets above one, which must read as exactly one.
    set_gain(LR_RESET);
    send_word(0, 16'h8000, 16'h8000, 13'd0);
    send_word(0, 16'h7FFF, 16'h7FFF, 13'd4096);
    send_word(0, 16'h8000, 16'h7FFF, 13'h1FFF);
    send_word(0, 16'h0000, 16'h0000, 13'd4097);
    send_word(1, 16'h0000, 16'h0000, 13'd0);
    send_word(1, 16'h1000, 16'h0000, 13'd4096);
    send_word(1, 16'h0000, 16'h1000, 13'd4096);
    send_word(1, 16'h1000, 16'h1000, 13'd0);
    send_word(1, 16'h7FFF, 16'h8000, 13'h1FFF);
    send_word(1, 16'h8000, 16'h7FFF, 13'd2048);
    send_word(1, 16'hFFFF, 16'h0001, 13'd1);
    send_word(0, 16'h5555, 16'hAAAA, 13'h0AAA);

    // Long receiver hold-off while the sender keeps offering: the output register
    // fills and the block must stall its input.
    hold_request = 700;
    calm_sender = 1;
    repeat (12) send_random();
    calm_sender = 0;
    drain();

    foreach (gains[p]) begin
      set_gain(gains[p]);
      calm_receiver = (p == 3);
      calm_sender = (p == 3);
      repeat (240) send_random();
      drain();
    end

    if (trainer_sb.mismatches == 0 && trainer_sb.pending.size() == 0)
      $display("mlp_backprop_trainer verification clean");
    else
      $display("mlp_backprop_trainer verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("mlp_backprop_trainer verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_ram.sv
hw/rtl/mbt_sig_builder.sv
hw/rtl/mlp_backprop_trainer.sv
bench/mlp_backprop_trainer_test.sv
